/* rtl/mlv1fp_pkg.sv */
// Package with the constants and types of the MAVLink v1 frame parser.
package mlv1fp_pkg;

  // Start-of-frame marker of a MAVLink v1 frame.
  localparam logic [7:0] START_BYTE = 8'hFE;

  // Width of the buffer position and fill count.
  localparam int POS_W = 9;

  // Buffer limit: the parser drops back to hunting once this many bytes are taken.
  localparam logic [POS_W-1:0] MAX_FRAME_BYTES = 9'd263;

  // Frame tracking phases, one-hot.
  typedef enum logic [7:0] {
    PH_HUNT = 8'b0000_0001,
    PH_LEN  = 8'b0000_0010,
    PH_SEQ  = 8'b0000_0100,
    PH_SYS  = 8'b0000_1000,
    PH_COMP = 8'b0001_0000,
    PH_MSG  = 8'b0010_0000,
    PH_DATA = 8'b0100_0000,
    PH_CKB  = 8'b1000_0000
  } phase_t;

endpackage

/* rtl/mavlink_v1_frame_parser.sv */
// MAVLink v1 frame parser: takes one received byte per beat and reports its place in the frame.
// Each accepted byte yields exactly one result beat, one byte per clock cycle while the result
// side does not stall; a byte passes from the input register through the frame tracking logic to the
// result register. The parser hunts for the start byte 0xFE, then takes length, sequence, system id,
// component id and message id, the payload and the two checksum bytes. Every byte taken into the
// frame comes out with byte_stored set and its buffer position, so that an outside buffer can keep
// it; the header fields of the current frame go out with every result, and frame_done marks the
// last checksum byte. The checksum is not checked. When the fill count reaches the buffer limit
// the parser returns to hunting. A stall on the result side holds the result register and, once
// the input register is also full, stalls the input side.
module mavlink_v1_frame_parser
  import mlv1fp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             frame_done,
  output logic             byte_stored,
  output logic [POS_W-1:0] byte_position,
  output logic [7:0]       payload_length,
  output logic [7:0]       sequence_res,
  output logic [7:0]       system_id,
  output logic [7:0]       component_id,
  output logic [7:0]       message_id
);

  // Input register.
  logic       in_q_valid;
  logic [7:0] byte_q;

  // Frame tracking state.
  phase_t           phase, phase_next;
  logic [7:0]       remaining, remaining_next;
  logic [POS_W-1:0] fill_count, fill_next;
  logic [7:0]       len_f, len_next;
  logic [7:0]       seq_f, seq_next;
  logic [7:0]       sys_f, sys_next;
  logic [7:0]       comp_f, comp_next;
  logic [7:0]       msg_f, msg_next;

  logic             stored, done;
  logic [POS_W-1:0] fill_base, pos;
  logic             advance, fire;

  // The result register moves when it is empty or being taken.
  assign advance  = !out_valid || !out_stall;
  assign fire     = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_q <= rx_byte;
    end
  end

  // Next state of the frame tracker for the byte in the input register.
  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    len_next       = len_f;
    seq_next       = seq_f;
    sys_next       = sys_f;
    comp_next      = comp_f;
    msg_next       = msg_f;
    stored         = 1'b1;
    done           = 1'b0;
    fill_base      = fill_count;
    unique case (phase)
      PH_HUNT: begin
        stored = 1'b0;
        if (byte_q == START_BYTE) begin
          stored     = 1'b1;
          len_next   = 8'd0;
          seq_next   = 8'd0;
          sys_next   = 8'd0;
          comp_next  = 8'd0;
          msg_next   = 8'd0;
          fill_base  = '0;
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        len_next       = byte_q;
        remaining_next = byte_q;
        phase_next     = PH_SEQ;
      end
      PH_SEQ: begin
        seq_next   = byte_q;
        phase_next = PH_SYS;
      end
      PH_SYS: begin
        sys_next   = byte_q;
        phase_next = PH_COMP;
      end
      PH_COMP: begin
        comp_next  = byte_q;
        phase_next = PH_MSG;
      end
      PH_MSG: begin
        msg_next   = byte_q;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        // Payload bytes count down; the byte after the last one is the first checksum byte.
        if (remaining == 8'd0) begin
          phase_next = PH_CKB;
        end else begin
          remaining_next = remaining - 8'd1;
        end
      end
      PH_CKB: begin
        done       = 1'b1;
        phase_next = PH_HUNT;
      end
      default: begin
        stored     = 1'b0;
        phase_next = PH_HUNT;
      end
    endcase

    pos       = stored ? fill_base : '0;
    fill_next = stored ? fill_base + 1'b1 : fill_count;

    // Buffer limit reached before the frame is complete: drop back to hunting.
    if (!done && fill_next == MAX_FRAME_BYTES) begin
      phase_next = PH_HUNT;
    end
  end

  // State update as each byte moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      remaining  <= 8'd0;
      fill_count <= '0;
      len_f      <= 8'd0;
      seq_f      <= 8'd0;
      sys_f      <= 8'd0;
      comp_f     <= 8'd0;
      msg_f      <= 8'd0;
    end else if (fire) begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      fill_count <= fill_next;
      len_f      <= len_next;
      seq_f      <= seq_next;
      sys_f      <= sys_next;
      comp_f     <= comp_next;
      msg_f      <= msg_next;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      frame_done     <= done;
      byte_stored    <= stored;
      byte_position  <= pos;
      payload_length <= len_next;
      sequence_res   <= seq_next;
      system_id      <= sys_next;
      component_id   <= comp_next;
      message_id     <= msg_next;
    end
  end

  // The last checksum byte is always a stored frame byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> byte_stored)
    else $error("frame_done without byte_stored");

  // A byte outside a frame carries position zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_stored |-> byte_position == '0)
    else $error("nonzero position on an unstored byte");

  // Positions stay inside the buffer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_position < MAX_FRAME_BYTES)
    else $error("byte_position beyond the buffer limit");

  // After a finished frame the tracker is hunting again.
  assert property (@(posedge clk) disable iff (rst)
    fire && done |=> phase == PH_HUNT)
    else $error("tracker not hunting after frame end");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the MAVLink v1 frame parser with a byte-level frame predictor.
`timescale 1ns / 100ps

module tb_top;
  import mlv1fp_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int RAND_BYTES  = 1250;
  localparam int IDLE_PCT    = 22;
  localparam int CALM_FROM   = 500;
  localparam int CALM_TO     = 750;
  localparam int DRAIN_WAIT  = 20;

  // One result beat of the parser.
  typedef struct packed {
    logic             done;
    logic             stored;
    logic [POS_W-1:0] pos;
    logic [7:0]       len;
    logic [7:0]       seq;
    logic [7:0]       sys;
    logic [7:0]       comp;
    logic [7:0]       msg;
  } parse_beat_t;

  // One pending input byte; hold makes the sender wait until all results are back.
  typedef struct {
    logic [7:0] b;
    bit         hold;
  } rx_item_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             frame_done;
  logic             byte_stored;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       payload_length;
  logic [7:0]       sequence_res;
  logic [7:0]       system_id;
  logic [7:0]       component_id;
  logic [7:0]       message_id;

  rx_item_t    rx_q[$];
  parse_beat_t parsed_q[$];

  int n_fail      = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_frames    = 0;
  int n_stored    = 0;
  int quiet_count = 0;

  // Predictor state: frame tracking phase, counters and header fields.
  phase_t           trk_phase = PH_HUNT;
  logic [7:0]       trk_left  = '0;
  logic [POS_W-1:0] trk_fill  = '0;
  logic [7:0]       hdr_len   = '0;
  logic [7:0]       hdr_seq   = '0;
  logic [7:0]       hdr_sys   = '0;
  logic [7:0]       hdr_comp  = '0;
  logic [7:0]       hdr_msg   = '0;

  mavlink_v1_frame_parser u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_done     (frame_done),
    .byte_stored    (byte_stored),
    .byte_position  (byte_position),
    .payload_length (payload_length),
    .sequence_res   (sequence_res),
    .system_id      (system_id),
    .component_id   (component_id),
    .message_id     (message_id)
  );

  always #5 clk = ~clk;

  // Advances the frame tracker by one byte and returns the beat it should produce.
  function automatic parse_beat_t parse_byte(input logic [7:0] b);
    parse_beat_t r;
    r = '0;
    if (trk_phase == PH_HUNT) begin
      // Only a start byte opens a frame; it wipes the previous header.
      if (b == START_BYTE) begin
        hdr_len   = '0;
        hdr_seq   = '0;
        hdr_sys   = '0;
        hdr_comp  = '0;
        hdr_msg   = '0;
        trk_fill  = '0;
        r.stored  = 1'b1;
        trk_phase = PH_LEN;
      end
    end else begin
      r.stored = 1'b1;
      case (trk_phase)
        PH_LEN: begin
          hdr_len   = b;
          trk_left  = b;
          trk_phase = PH_SEQ;
        end
        PH_SEQ: begin
          hdr_seq   = b;
          trk_phase = PH_SYS;
        end
        PH_SYS: begin
          hdr_sys   = b;
          trk_phase = PH_COMP;
        end
        PH_COMP: begin
          hdr_comp  = b;
          trk_phase = PH_MSG;
        end
        PH_MSG: begin
          hdr_msg   = b;
          trk_phase = PH_DATA;
        end
        PH_DATA: begin
          // With nothing left, this byte is the first checksum byte.
          if (trk_left == 8'd0) trk_phase = PH_CKB;
          else trk_left = trk_left - 8'd1;
        end
        default: begin
          trk_phase = PH_HUNT;
          r.done    = 1'b1;
        end
      endcase
    end
    if (r.stored) begin
      r.pos    = trk_fill;
      trk_fill = trk_fill + 1'b1;
    end
    // A full buffer drops the frame unless it just completed.
    if (!r.done && trk_fill == MAX_FRAME_BYTES) trk_phase = PH_HUNT;
    r.len  = hdr_len;
    r.seq  = hdr_seq;
    r.sys  = hdr_sys;
    r.comp = hdr_comp;
    r.msg  = hdr_msg;
    return r;
  endfunction

  // Reports one field mismatch.
  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input bit hold = 1'b0);
    rx_item_t it;
    it.b    = b;
    it.hold = hold;
    rx_q.push_back(it);
  endtask

  // Queues a well-formed frame with the given header and random payload and checksum.
  task automatic push_frame(input logic [7:0] len, input logic [7:0] seq, input logic [7:0] sys,
                            input logic [7:0] comp, input logic [7:0] msg, input bit hold);
    push_byte(START_BYTE, hold);
    push_byte(len);
    push_byte(seq);
    push_byte(sys);
    push_byte(comp);
    push_byte(msg);
    for (int i = 0; i < len; i++) push_byte(8'($urandom));
    push_byte(8'($urandom));
    push_byte(8'($urandom));
  endtask

  // Driver: presents queued bytes, predicts each accepted beat, idles at random.
  always @(posedge clk) begin
    logic fire;
    logic idle;
    fire = in_valid && !in_stall;
    idle = ($urandom_range(99) < IDLE_PCT) && !(n_sent >= CALM_FROM && n_sent < CALM_TO);
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        parsed_q.push_back(parse_byte(rx_byte));
        n_sent++;
      end
      if (!in_valid || fire) begin
        if (rx_q.size() != 0 && !idle && !(rx_q[0].hold && parsed_q.size() != 0)) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_q[0].b;
          void'(rx_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    parse_beat_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parsed_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result beat, expected none, actual byte_position %0d",
                   $realtime, byte_position);
        end else begin
          e = parsed_q.pop_front();
          check_field("frame_done", e.done, frame_done);
          check_field("byte_stored", e.stored, byte_stored);
          check_field("byte_position", e.pos, byte_position);
          check_field("payload_length", e.len, payload_length);
          check_field("sequence_res", e.seq, sequence_res);
          check_field("system_id", e.sys, system_id);
          check_field("component_id", e.comp, component_id);
          check_field("message_id", e.msg, message_id);
          n_frames += e.done;
          n_stored += e.stored;
        end
        n_checked++;
      end
      out_stall <= ($urandom_range(99) < IDLE_PCT) &&
                   !(n_checked >= CALM_FROM && n_checked < CALM_TO);
    end
  end

  // Watchdog: ends the run when neither side moves a beat for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_count <= 0;
      else quiet_count <= quiet_count + 1;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $realtime, quiet_count);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int n_queued;
    int r;
    n_queued = 0;

    // Directed part: noise while hunting, extreme header values, zero length,
    // a start byte inside a frame, and noise between frames.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h55);
    push_frame(8'd0, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
    push_byte(START_BYTE);
    push_byte(8'd2);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(START_BYTE);
    push_byte(8'h01);
    push_byte(START_BYTE);
    push_byte(8'h80);
    push_byte(8'hAA);

    // A full-size frame after the parser has drained.
    push_frame(8'd255, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    n_queued += 263;

    // Random part: mostly well-formed frames, with hunting noise and garbage bursts.
    while (n_queued < RAND_BYTES) begin
      r = $urandom_range(99);
      if (r < 30) begin
        for (int i = $urandom_range(4); i > 0; i--) push_byte(8'($urandom_range(8'hFD)));
      end
      r = $urandom_range(99);
      if (r < 10) begin
        // Garbage burst that may itself contain start bytes.
        for (int i = $urandom_range(12, 1); i > 0; i--) begin
          push_byte(($urandom_range(3) == 0) ? START_BYTE : 8'($urandom));
          n_queued++;
        end
      end else begin
        int len;
        r = $urandom_range(99);
        if (r < 82) len = $urandom_range(16);
        else if (r < 97) len = $urandom_range(80, 17);
        else len = $urandom_range(255, 200);
        push_frame(8'(len), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   (n_queued > 700 && n_queued < 720));
        n_queued += len + 8;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait until every byte is accepted and every result has been checked.
    @(negedge clk);
    while (rx_q.size() != 0 || in_valid || parsed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (parsed_q.size() != 0) begin
      n_fail++;
      $display("%0t: %0d expected result beats never arrived", $realtime, parsed_q.size());
    end
    $display("Run covered %0d input bytes and %0d result beats: %0d stored bytes, %0d frames.",
             n_sent, n_checked, n_stored, n_frames);
    $display("Mismatches found: %0d.", n_fail);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
